// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lfia_pkg.sv =====
// ----------------------------------------------------------------------------
// lfia_pkg
// Types, codes and helper functions for the lowest free id allocator.
// ----------------------------------------------------------------------------
package lfia_pkg;

  // Requester identifier width on the input port.
  localparam int PID_W = 8;

  // The busy map is searched in chunks of this many ids.
  localparam int CHUNK_W     = 64;
  localparam int CHUNK_IDX_W = 6;

  // Operation codes carried by in_mode.
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_UNMAPPED = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } lfia_state_t;

  // Position of the lowest set bit of a 64-bit word, found by halving the
  // search window six times. The result is meaningless for an all-zero word.
  function automatic logic [CHUNK_IDX_W-1:0] ffs64(input logic [CHUNK_W-1:0] v);
    logic [CHUNK_W-1:0]     t;
    logic [CHUNK_W-1:0]     m;
    logic [CHUNK_IDX_W-1:0] p;
    t = v;
    p = '0;
    for (int k = CHUNK_IDX_W - 1; k >= 0; k--) begin
      m = (64'd1 << (1 << k)) - 64'd1;
      if ((t & m) == '0) begin
        p[k] = 1'b1;
        t    = t >> (1 << k);
      end
    end
    return p;
  endfunction

endpackage

// ===== design/lowest_free_id_allocator.sv =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Grants the lowest free resource id to a requester and frees it on request.
// ----------------------------------------------------------------------------
// A word is accepted at a rising edge with start high and busy low. Mode add
// grants the lowest free id (1..RESOURCE_COUNT) and records it for the
// requester; mode remove frees the id that the requester owns. Each word
// gives exactly one result word, shown for one cycle with out_valid high, from
// the output registers after the execute state and the report stage; the
// receiver cannot stall it. Busy is high in the execute state after each accept,
// so a new word waits until the last leaves execute. This limit is set by the
// owner table, a one-port synchronous RAM that is read in the accept cycle and
// written back in the following cycle. After reset, busy stays high while a
// clearing pass writes every owner entry to zero. Process ids wrap modulo
// REQUESTER_SLOTS. A re-add of a mapped requester leaves its old id busy and
// orphaned; an add with nothing free reports status full.
module lowest_free_id_allocator
  import lfia_pkg::*;
#(
  parameter int REQUESTER_SLOTS = 256,
  parameter int RESOURCE_COUNT  = 64,
  localparam int ID_W           = $clog2(RESOURCE_COUNT + 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_mode,
  input  logic [PID_W-1:0] in_process_id,
  output logic             out_valid,
  output logic [ID_W-1:0]  out_granted_id,
  output logic [1:0]       out_status,
  output logic [ID_W-1:0]  out_smallest_free
);

`include "assert_macros.svh"

  localparam int SLOT_W = $clog2(REQUESTER_SLOTS);
  localparam int BIT_W  = $clog2(RESOURCE_COUNT);
  localparam int NCH    = (RESOURCE_COUNT + CHUNK_W - 1) / CHUNK_W;
  localparam int CI_W   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int NCH_P  = 1 << CI_W;
  localparam int PAD_W  = NCH_P * CHUNK_W;

  // Reduce a process id modulo the table depth by conditional subtraction,
  // one step per input bit.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [PID_W-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = PID_W - 1; k >= 0; k--) begin
      if (r >= (32'(REQUESTER_SLOTS) << k)) begin
        r = r - (32'(REQUESTER_SLOTS) << k);
      end
    end
    return SLOT_W'(r);
  endfunction

  // Control.
  lfia_state_t state_r, state_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic accept, exec, clearing;

  // Owner table RAM.
  logic [ID_W-1:0]   owner_mem [REQUESTER_SLOTS];
  logic [ID_W-1:0]   mem_q_r;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [ID_W-1:0]   mem_wdata;
  logic [SLOT_W-1:0] in_slot;

  // Execute stage.
  logic              e_mode_r;
  logic [SLOT_W-1:0] e_slot_r;
  logic [ID_W-1:0]   grant;
  logic [1:0]        stat;
  logic              own_we;
  logic [ID_W-1:0]   own_wdata;
  logic [BIT_W-1:0]  bit_idx;

  // Busy map and the cached lowest free id.
  logic [RESOURCE_COUNT-1:0] busy_map_r, busy_map_nxt;
  logic [ID_W-1:0]           sf_r;

  // Per-chunk search results, registered between the two search levels.
  logic [PAD_W-1:0]       free_pad;
  logic [NCH_P-1:0]       chunk_free_nxt, chunk_free_r;
  logic [CHUNK_IDX_W-1:0] chunk_off_nxt [NCH_P];
  logic [CHUNK_IDX_W-1:0] chunk_off_r   [NCH_P];

  // Report stage.
  logic                   r_v_r;
  logic [ID_W-1:0]        r_grant_r;
  logic [1:0]             r_stat_r;
  logic [CHUNK_IDX_W-1:0] ci_full;
  logic [CI_W-1:0]        ci;
  logic [CHUNK_IDX_W-1:0] sel_off;
  logic                   any_free;
  logic [ID_W-1:0]        sf_calc;

  // Output registers.
  logic            out_valid_r;
  logic [ID_W-1:0] out_granted_id_r;
  logic [1:0]      out_status_r;
  logic [ID_W-1:0] out_smallest_free_r;

  // ---------------------------------------------------------------------------
  // State machine: clearing pass after reset, then idle / execute.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == SLOT_W'(REQUESTER_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    accept   = 1'b0;
    exec     = 1'b0;
    clearing = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clearing = 1'b1;
      end
      S_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      S_EXEC: begin
        exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign clr_cnt_nxt = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Owner table. Read in the accept cycle; written back in the execute cycle,
  // so the next word's read always sees the previous word's write.
  // ---------------------------------------------------------------------------
  assign in_slot   = slot_of(in_process_id);
  assign mem_we    = clearing || (exec && own_we);
  assign mem_waddr = clearing ? clr_cnt_r : e_slot_r;
  assign mem_wdata = clearing ? '0 : own_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      owner_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_q_r <= owner_mem[in_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_mode_r <= in_mode;
      e_slot_r <= in_slot;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute: grant or free one id and update the busy map. The lowest free id
  // is kept in sf_r, so an add needs no search before granting.
  // ---------------------------------------------------------------------------
  always_comb begin
    grant        = '0;
    stat         = STAT_OK;
    own_we       = 1'b0;
    own_wdata    = '0;
    bit_idx      = '0;
    busy_map_nxt = busy_map_r;
    if (e_mode_r == MODE_ADD) begin
      if (sf_r > ID_W'(RESOURCE_COUNT)) begin
        stat = STAT_FULL;
      end else begin
        grant                 = sf_r;
        own_we                = 1'b1;
        own_wdata             = sf_r;
        bit_idx               = BIT_W'(sf_r - 1'b1);
        busy_map_nxt[bit_idx] = 1'b1;
      end
    end else begin
      if (mem_q_r == '0) begin
        stat = STAT_UNMAPPED;
      end else begin
        grant                 = mem_q_r;
        own_we                = 1'b1;
        own_wdata             = '0;
        bit_idx               = BIT_W'(mem_q_r - 1'b1);
        busy_map_nxt[bit_idx] = 1'b0;
      end
    end
  end

  // First search level: lowest free id within each 64-id chunk of the
  // updated map. Ids past the end of the range are padded as busy.
  always_comb begin
    free_pad                     = '0;
    free_pad[RESOURCE_COUNT-1:0] = ~busy_map_nxt;
    for (int c = 0; c < NCH_P; c++) begin
      chunk_free_nxt[c] = |free_pad[c*CHUNK_W +: CHUNK_W];
      chunk_off_nxt[c]  = ffs64(free_pad[c*CHUNK_W +: CHUNK_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_map_r <= '0;
    end else if (exec) begin
      busy_map_r <= busy_map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      r_grant_r    <= grant;
      r_stat_r     <= stat;
      chunk_free_r <= chunk_free_nxt;
      chunk_off_r  <= chunk_off_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Report: second search level picks the lowest chunk with a free id, which
  // gives the new lowest free id for both the result and the next add.
  // ---------------------------------------------------------------------------
  assign ci_full  = ffs64(CHUNK_W'(chunk_free_r));
  assign ci       = ci_full[CI_W-1:0];
  assign sel_off  = chunk_off_r[ci];
  assign any_free = |chunk_free_r;
  assign sf_calc  = any_free ? ID_W'({ci_full, sel_off} + 12'd1)
                             : ID_W'(RESOURCE_COUNT + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      sf_r        <= ID_W'(1);
    end else begin
      r_v_r       <= exec;
      out_valid_r <= r_v_r;
      if (r_v_r) begin
        sf_r <= sf_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_v_r) begin
      out_granted_id_r    <= r_grant_r;
      out_status_r        <= r_stat_r;
      out_smallest_free_r <= sf_calc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_id    = out_granted_id_r;
  assign out_status        = out_status_r;
  assign out_smallest_free = out_smallest_free_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_IMPL(a_result_follows_exec, state_r == S_EXEC, ##2 out_valid_r, "execute without result")
  `ASSERT_IMPL(a_grant_in_range, out_valid_r, out_granted_id <= ID_W'(RESOURCE_COUNT), "grant out of range")
  `ASSERT_IMPL(a_full_means_none, out_valid_r && out_status == STAT_FULL, out_granted_id == '0 && out_smallest_free == ID_W'(RESOURCE_COUNT + 1), "full with free id")
  `ASSERT_NEXT(a_map_only_in_exec, state_r != S_EXEC, $stable(busy_map_r), "busy map changed outside execute")

endmodule
